### hw/rtl/pts_pkg.sv
// Package for the process table scheduler.
// Holds command, task state and status codes, the table word layout and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int PID_W          = 11;
    localparam int FIRST_PID_W    = 10;
    localparam int ADDR_W         = 32;
    localparam int RUNS_W         = 32;
    localparam int GROUP_W        = 32;
    localparam logic [FIRST_PID_W-1:0] FIRST_PID_RESET = 10'd1000;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_KILL    = 2'd1,
        CMD_UNBLOCK = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        TS_RUNNABLE = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_BLOCKED  = 2'd2,
        TS_DEAD     = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        OUTC_YIELD = 2'd0,
        OUTC_BLOCK = 2'd1,
        OUTC_EXIT  = 2'd2,
        OUTC_OTHER = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_FULL      = 3'd1,
        RS_NOTFOUND  = 3'd2,
        RS_BADSTATE  = 3'd3,
        RS_IDLE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PICK,
        S_READ,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic              kill;
        task_state_t       state;
        logic [ADDR_W-1:0] entry;
        logic [RUNS_W-1:0] runs;
    } table_word_t;

    typedef struct packed {
        logic capture;
        logic look;
        logic pick;
        logic commit;
    } dp_ctl_t;

    typedef struct packed {
        logic is_tick;
    } dp_stat_t;

endpackage

### hw/rtl/pts_ctrl.sv
// Controller state machine of the process table scheduler.
// Sequences lookup, pick, table read and commit; owns the result valid flag.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pts_pkg::dp_stat_t stat,
    output pts_pkg::dp_ctl_t  ctl
);

    pts_pkg::ctrl_state_t state_reg;
    pts_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pts_pkg::S_LOOK;
                end
            end
            pts_pkg::S_LOOK:
            begin
                state_next = stat.is_tick ? pts_pkg::S_PICK : pts_pkg::S_READ;
            end
            pts_pkg::S_PICK:
            begin
                state_next = pts_pkg::S_READ;
            end
            pts_pkg::S_READ:
            begin
                state_next = pts_pkg::S_EXEC;
            end
            pts_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = pts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == pts_pkg::S_IDLE);
        ctl.capture    = in_ready && in_valid;
        ctl.look       = (state_reg == pts_pkg::S_LOOK);
        ctl.pick       = (state_reg == pts_pkg::S_PICK);
        ctl.commit     = (state_reg == pts_pkg::S_EXEC) && out_free;
        out_valid_next = out_valid_reg && !out_ready;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pts_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/pts_datapath.sv
// Datapath of the process table scheduler: task table memory, runnable
// vector, pid counters, two-step priority pick and result registers.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_datapath #(
    parameter int DEPTH = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pts_pkg::FIRST_PID_W-1:0]     cfg_wr_data,
    input  logic [1:0]                          cmd,
    input  logic [pts_pkg::PID_W-1:0]           target_pid,
    input  logic [pts_pkg::ADDR_W-1:0]          entry_addr,
    input  logic [1:0]                          run_outcome,
    input  pts_pkg::dp_ctl_t                    ctl,
    output pts_pkg::dp_stat_t                   stat,
    output logic [2:0]                          status,
    output logic [pts_pkg::PID_W-1:0]           pid_out,
    output logic [pts_pkg::ADDR_W-1:0]          entry_out,
    output logic [pts_pkg::RUNS_W-1:0]          runs_out,
    output logic [1:0]                          final_state
);

    localparam int IW  = $clog2(DEPTH);
    localparam int UW  = $clog2(DEPTH + 1);
    localparam int PW  = pts_pkg::PID_W;
    localparam int GW  = pts_pkg::GROUP_W;
    localparam int GBW = $clog2(GW);
    localparam int NG  = (DEPTH + GW - 1) / GW;
    localparam int GIW = (NG > 1) ? $clog2(NG) : 1;

    pts_pkg::table_word_t table_mem [DEPTH];

    pts_pkg::cmd_t          cmd_reg;
    logic [PW-1:0]          tpid_reg;
    logic [pts_pkg::ADDR_W-1:0] addr_reg;
    pts_pkg::outcome_t      outcome_reg;
    logic [UW-1:0]          used_reg;
    logic [PW-1:0]          next_pid_reg;
    logic [DEPTH-1:0]       runnable_reg;
    logic [IW-1:0]          idx_reg;
    logic                   found_reg;
    logic [GIW-1:0]         grp_reg;
    logic                   any_reg;
    pts_pkg::table_word_t   rd_reg;
    pts_pkg::status_t       status_reg;
    logic [PW-1:0]          pid_reg;
    logic [pts_pkg::ADDR_W-1:0] entry_reg;
    logic [pts_pkg::RUNS_W-1:0] runs_reg;
    pts_pkg::task_state_t   fstate_reg;

    logic [PW-1:0]          base_pid;
    logic [PW-1:0]          pid_off;
    logic                   lookup_hit;
    logic                   table_full;
    logic [NG*GW-1:0]       rvec_pad;
    logic [NG-1:0][GW-1:0]  rvec_words;
    logic [GW-1:0]          grp_word;
    logic                   grp_any;
    logic [GIW-1:0]         grp_sel;
    logic [GBW-1:0]         bit_sel;
    logic [IW-1:0]          pick_idx;
    logic [pts_pkg::RUNS_W-1:0] runs_inc;
    pts_pkg::task_state_t   tick_state;

    logic                   wr_en;
    pts_pkg::table_word_t   wr_word;
    logic                   rv_write;
    logic                   rv_val;
    logic                   create_ok;
    pts_pkg::status_t       res_status;
    logic [PW-1:0]          res_pid;
    logic [pts_pkg::ADDR_W-1:0] res_entry;
    logic [pts_pkg::RUNS_W-1:0] res_runs;
    pts_pkg::task_state_t   res_state;

    // Pids are handed out in order and never reused, so entry i holds base + i.
    assign base_pid   = next_pid_reg - PW'(used_reg);
    assign pid_off    = tpid_reg - base_pid;
    assign lookup_hit = ({1'b0, pid_off} < (PW + 1)'(used_reg));
    assign table_full = (used_reg == UW'(DEPTH));
    assign stat.is_tick = (cmd_reg == pts_pkg::CMD_TICK);

    assign rvec_pad   = (NG * GW)'(runnable_reg);
    assign rvec_words = rvec_pad;
    assign grp_word   = rvec_words[grp_reg];

    always_comb
    begin
        grp_any = 1'b0;
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (|rvec_words[g])
            begin
                grp_any = 1'b1;
                grp_sel = GIW'(g);
            end
        end
    end

    always_comb
    begin
        bit_sel = '0;
        for (int b = GW - 1; b >= 0; b--)
        begin
            if (grp_word[b])
            begin
                bit_sel = GBW'(b);
            end
        end
    end

    assign pick_idx = IW'({grp_reg, bit_sel});
    assign runs_inc = (&rd_reg.runs) ? rd_reg.runs : rd_reg.runs + 1'b1;

    always_comb
    begin
        priority if (rd_reg.kill)
        begin
            tick_state = pts_pkg::TS_DEAD;
        end
        else if (outcome_reg == pts_pkg::OUTC_BLOCK)
        begin
            tick_state = pts_pkg::TS_BLOCKED;
        end
        else if (outcome_reg == pts_pkg::OUTC_EXIT)
        begin
            tick_state = pts_pkg::TS_DEAD;
        end
        else
        begin
            tick_state = pts_pkg::TS_RUNNABLE;
        end
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_word    = rd_reg;
        rv_write   = 1'b0;
        rv_val     = 1'b0;
        create_ok  = 1'b0;
        res_status = pts_pkg::RS_OK;
        res_pid    = '0;
        res_entry  = '0;
        res_runs   = '0;
        res_state  = pts_pkg::TS_RUNNABLE;
        unique case (cmd_reg)
            pts_pkg::CMD_CREATE:
            begin
                if (!found_reg)
                begin
                    res_status = pts_pkg::RS_FULL;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_word.kill  = 1'b0;
                    wr_word.state = pts_pkg::TS_RUNNABLE;
                    wr_word.entry = addr_reg;
                    wr_word.runs  = '0;
                    rv_write      = 1'b1;
                    rv_val        = 1'b1;
                    create_ok     = 1'b1;
                    res_pid       = next_pid_reg;
                end
            end
            pts_pkg::CMD_KILL:
            begin
                if (!found_reg)
                begin
                    res_status = pts_pkg::RS_NOTFOUND;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_word.kill = 1'b1;
                    res_state    = rd_reg.state;
                end
            end
            pts_pkg::CMD_UNBLOCK:
            begin
                if (!found_reg)
                begin
                    res_status = pts_pkg::RS_NOTFOUND;
                end
                else if (rd_reg.state != pts_pkg::TS_BLOCKED)
                begin
                    res_status = pts_pkg::RS_BADSTATE;
                    res_state  = rd_reg.state;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_word.state = pts_pkg::TS_RUNNABLE;
                    rv_write      = 1'b1;
                    rv_val        = 1'b1;
                end
            end
            pts_pkg::CMD_TICK:
            begin
                if (!found_reg)
                begin
                    res_status = pts_pkg::RS_IDLE;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_word.runs  = runs_inc;
                    wr_word.state = tick_state;
                    rv_write      = 1'b1;
                    rv_val        = (tick_state == pts_pkg::TS_RUNNABLE);
                    res_pid       = base_pid + PW'(idx_reg);
                    res_entry     = rd_reg.entry;
                    res_runs      = runs_inc;
                    res_state     = tick_state;
                end
            end
            default:
            begin
                res_status = pts_pkg::RS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            next_pid_reg <= PW'(pts_pkg::FIRST_PID_RESET);
            runnable_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en && (used_reg == '0))
            begin
                next_pid_reg <= PW'(cfg_wr_data);
            end
            if (ctl.commit && create_ok)
            begin
                used_reg     <= used_reg + 1'b1;
                next_pid_reg <= next_pid_reg + 1'b1;
            end
            if (ctl.commit && rv_write)
            begin
                runnable_reg[idx_reg] <= rv_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= pts_pkg::cmd_t'(cmd);
            tpid_reg    <= target_pid;
            addr_reg    <= entry_addr;
            outcome_reg <= pts_pkg::outcome_t'(run_outcome);
        end
        if (ctl.look)
        begin
            if (cmd_reg == pts_pkg::CMD_TICK)
            begin
                grp_reg <= grp_sel;
                any_reg <= grp_any;
            end
            else if (cmd_reg == pts_pkg::CMD_CREATE)
            begin
                idx_reg   <= used_reg[IW-1:0];
                found_reg <= !table_full;
            end
            else
            begin
                idx_reg   <= pid_off[IW-1:0];
                found_reg <= lookup_hit;
            end
        end
        if (ctl.pick)
        begin
            idx_reg   <= pick_idx;
            found_reg <= any_reg;
        end
        if (ctl.commit)
        begin
            status_reg <= res_status;
            pid_reg    <= res_pid;
            entry_reg  <= res_entry;
            runs_reg   <= res_runs;
            fstate_reg <= res_state;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && wr_en)
        begin
            table_mem[idx_reg] <= wr_word;
        end
        rd_reg <= table_mem[idx_reg];
    end

    assign status      = status_reg;
    assign pid_out     = pid_reg;
    assign entry_out   = entry_reg;
    assign runs_out    = runs_reg;
    assign final_state = fstate_reg;

endmodule

### hw/rtl/process_table_scheduler.sv
// A result is registered through the lookup, table read and commit states, and a tick
// also passes the pick state. Items are not overlapped: a new item is taken only after
// the table memory read-modify-write and, for a tick, the two-step group/bit priority pick.
// An item can be taken while the previous result still waits at the output.
// Reset clears control, fill count and runnable vector and loads next pid 1000;
// the table memory is not cleared, entries are written before being read.
`timescale 1ns / 1ps

module process_table_scheduler #(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pts_pkg::FIRST_PID_W-1:0] cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [pts_pkg::PID_W-1:0]       target_pid,
    input  logic [pts_pkg::ADDR_W-1:0]      entry_addr,
    input  logic [1:0]                      run_outcome,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [pts_pkg::PID_W-1:0]       pid_out,
    output logic [pts_pkg::ADDR_W-1:0]      entry_out,
    output logic [pts_pkg::RUNS_W-1:0]      runs_out,
    output logic [1:0]                      final_state
);

    pts_pkg::dp_ctl_t  ctl;
    pts_pkg::dp_stat_t stat;

    pts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    pts_datapath #(
        .DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .target_pid  (target_pid),
        .entry_addr  (entry_addr),
        .run_outcome (run_outcome),
        .ctl         (ctl),
        .stat        (stat),
        .status      (status),
        .pid_out     (pid_out),
        .entry_out   (entry_out),
        .runs_out    (runs_out),
        .final_state (final_state)
    );

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input transfer taken while an item is in flight");

    a_never_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_state != pts_pkg::TS_RUNNING)
        else $error("running state reported");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == pts_pkg::RS_IDLE || status == pts_pkg::RS_FULL)
        |-> pid_out == '0 && runs_out == '0 && entry_out == '0)
        else $error("fields set on idle tick or full table");

    a_tick_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pts_pkg::RS_OK && runs_out != '0
        |-> final_state != pts_pkg::TS_RUNNING)
        else $error("picked entry reported without run outcome applied");

endmodule
